>>> hdl/ais_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ais_pkg
// Shared constants and types for the ascending integer sorter.
// ----------------------------------------------------------------------------
package ais_pkg;

   // fixed port width of the value fields
   localparam int VALUE_BITS        = 32;

   // defaults for the top level parameters
   localparam int MAX_ITEMS_DEF     = 64;
   localparam int VALUE_WIDTH_DEF   = 32;

   // per-cycle command broadcast to every cell of the chain
   typedef struct packed {
      logic insert;   // place the incoming word in sorted position
      logic shift;    // move every held word one cell toward the output
   } ctrl_type;

endpackage

>>> hdl/ais_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ais_cell
// One slot of the insertion chain. It holds one value and a valid bit,
// compares the broadcast word against its value, and trades values with
// its neighbors on insert and on drain.
// ----------------------------------------------------------------------------
module ais_cell #(
   parameter int VALUE_WIDTH = ais_pkg::VALUE_WIDTH_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  ais_pkg::ctrl_type       ctrl,
   input  logic [VALUE_WIDTH-1:0]  new_value,
   input  logic                    left_valid,
   input  logic                    left_gt,
   input  logic [VALUE_WIDTH-1:0]  left_value,
   input  logic                    right_valid,
   input  logic [VALUE_WIDTH-1:0]  right_value,
   output logic                    valid,
   output logic                    gt,
   output logic [VALUE_WIDTH-1:0]  value
);

   logic                   valid_ff;
   logic                   valid_in;
   logic [VALUE_WIDTH-1:0] value_ff;
   logic [VALUE_WIDTH-1:0] value_in;
   logic [VALUE_WIDTH-1:0] own_key;
   logic [VALUE_WIDTH-1:0] new_key;
   logic                   take;

   // flipping the sign bit turns signed order into unsigned order
   assign own_key = {~value_ff[VALUE_WIDTH-1], value_ff[VALUE_WIDTH-2:0]};
   assign new_key = {~new_value[VALUE_WIDTH-1], new_value[VALUE_WIDTH-2:0]};

   // strictly greater keeps equal values in arrival order
   assign gt   = valid_ff && (own_key > new_key);
   // cells above the insertion point move up, the first empty cell fills
   assign take = gt || (!valid_ff && left_valid);

   always_comb begin
      valid_in = valid_ff;
      value_in = value_ff;
      if (ctrl.shift) begin
         valid_in = right_valid;
         value_in = right_value;
      end else if (ctrl.insert && take) begin
         valid_in = 1'b1;
         value_in = left_gt ? left_value : new_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign valid = valid_ff;
   assign value = value_ff;

endmodule

>>> hdl/ascending_integer_sorter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascending_integer_sorter
// Collects a batch of signed integers in a self-sorting chain of cells and
// drains the batch in non-decreasing order when the last word arrives.
// ----------------------------------------------------------------------------
//
//   channel  dir   ports                                       handshake
//   req      in    req_value, req_last                         req_valid / req_stall
//   rsp      out   rsp_value_res, rsp_last_res, rsp_overflow   rsp_valid / rsp_stall
//
// cycles: a word is taken every cycle while loading; each word finds its
//   place by a compare in every cell of the chain
// drain: after the last word, one sorted word leaves per cycle from the head
//   cell while rsp_stall is low and the chain shifts toward it; req_stall is high for the drain
// reset: clears the valid bits and control, no clearing pass is needed
// stalls: rsp_stall freezes the chain with the head word on the outputs
//
module ascending_integer_sorter #(
   parameter int MAX_ITEMS   = ais_pkg::MAX_ITEMS_DEF,
   parameter int VALUE_WIDTH = ais_pkg::VALUE_WIDTH_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [ais_pkg::VALUE_BITS-1:0] req_value,
   input  logic                                  req_last,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [ais_pkg::VALUE_BITS-1:0] rsp_value_res,
   output logic                                  rsp_last_res,
   output logic                                  rsp_overflow
);

   localparam int VB = ais_pkg::VALUE_BITS;

   logic                   draining_ff;
   logic                   draining_in;
   logic                   dropped_ff;
   logic                   dropped_in;
   logic                   req_accept;
   logic                   rsp_accept;
   logic                   full;
   logic [VALUE_WIDTH-1:0] new_value;
   ais_pkg::ctrl_type      ctrl;

   logic [MAX_ITEMS-1:0]   cell_valid;
   logic [MAX_ITEMS-1:0]   cell_gt;
   logic [VALUE_WIDTH-1:0] cell_value [MAX_ITEMS];

   assign req_stall  = draining_ff;
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = draining_ff;
   assign rsp_accept = rsp_valid && !rsp_stall;
   assign full       = cell_valid[MAX_ITEMS-1];

   // input word narrowed or zero extended to the stored width
   generate
      if (VALUE_WIDTH <= VB) begin : g_in_narrow
         assign new_value = req_value[VALUE_WIDTH-1:0];
      end else begin : g_in_wide
         assign new_value = {{(VALUE_WIDTH-VB){1'b0}}, req_value};
      end
   endgenerate

   assign ctrl.insert = req_accept && !full;
   assign ctrl.shift  = rsp_accept;

   generate
      for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
         logic                   l_valid;
         logic                   l_gt;
         logic [VALUE_WIDTH-1:0] l_value;
         logic                   r_valid;
         logic [VALUE_WIDTH-1:0] r_value;

         if (i == 0) begin : g_head
            assign l_valid = 1'b1;
            assign l_gt    = 1'b0;
            assign l_value = '0;
         end else begin : g_body
            assign l_valid = cell_valid[i-1];
            assign l_gt    = cell_gt[i-1];
            assign l_value = cell_value[i-1];
         end

         if (i == MAX_ITEMS-1) begin : g_tail
            assign r_valid = 1'b0;
            assign r_value = '0;
         end else begin : g_inner
            assign r_valid = cell_valid[i+1];
            assign r_value = cell_value[i+1];
         end

         ais_cell #(
            .VALUE_WIDTH (VALUE_WIDTH)
         ) u_cell (
            .clock       (clock),
            .reset       (reset),
            .ctrl        (ctrl),
            .new_value   (new_value),
            .left_valid  (l_valid),
            .left_gt     (l_gt),
            .left_value  (l_value),
            .right_valid (r_valid),
            .right_value (r_value),
            .valid       (cell_valid[i]),
            .gt          (cell_gt[i]),
            .value       (cell_value[i])
         );
      end
   endgenerate

   always_comb begin
      draining_in = draining_ff;
      dropped_in  = dropped_ff;
      if (req_accept) begin
         if (full) begin
            dropped_in = 1'b1;
         end
         if (req_last) begin
            draining_in = 1'b1;
         end
      end
      // final word of the batch leaves: start over empty
      if (rsp_accept && rsp_last_res) begin
         draining_in = 1'b0;
         dropped_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         draining_ff <= 1'b0;
         dropped_ff  <= 1'b0;
      end else begin
         draining_ff <= draining_in;
         dropped_ff  <= dropped_in;
      end
   end

   generate
      if (VALUE_WIDTH >= VB) begin : g_out_wide
         assign rsp_value_res = cell_value[0][VB-1:0];
      end else begin : g_out_narrow
         assign rsp_value_res = {{(VB-VALUE_WIDTH){1'b0}}, cell_value[0]};
      end
   endgenerate

   assign rsp_last_res = !cell_valid[1];
   assign rsp_overflow = dropped_ff;

`ifndef SYNTH
   // held words always fill the chain from the head with no gaps
   a_contiguous: assert property (@(posedge clock) disable iff (reset)
      (cell_valid & (cell_valid + MAX_ITEMS'(1))) == '0)
      else $error("cell valid bits not contiguous from head");

   // a word is on offer only when the head cell holds one
   a_head_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> cell_valid[0])
      else $error("result offered from empty head cell");

   // after the final word of a batch the chain is empty
   a_empty_after: assert property (@(posedge clock) disable iff (reset)
      (rsp_accept && rsp_last_res) |=> (cell_valid == '0) && !dropped_ff)
      else $error("chain not empty after batch drained");

   // a word taken while full is dropped and flagged
   a_drop_flag: assert property (@(posedge clock) disable iff (reset)
      (req_accept && full) |=> dropped_ff && full)
      else $error("dropped word not flagged");
`endif

endmodule
